// ===== rtl/cpra_pkg.sv =====
// Shared types and constants for the contiguous page run allocator.
package cpra_pkg;

    // Widths of the item fields seen at the ports.
    localparam int W_OP        = 1;
    localparam int W_REQ       = 12;
    localparam int W_PAGE_IN   = 10;
    localparam int W_RUN_START = 10;
    localparam int W_COUNT     = 11;

    typedef enum logic [W_OP-1:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;      // clearing pass: zero both stores at the write pointer
        logic load;       // capture the accepted item
        logic scan_p1;    // start the search at the hint
        logic scan_p2;    // start the search at page 0, bounded by the hint
        logic scan;       // advance the bitmap scan by one page
        logic mark;       // set one used bit of the placed run
        logic rel_start;  // take the run length, clear it and start releasing
        logic release_pg; // clear one used bit of the released run
        logic set_fail;   // result is a rejection
        logic out_load;   // move the result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_free;
        logic want_bad;
        logic page_bad;
        logic hit;
        logic pass_done;
        logic mark_last;
        logic len_zero;
        logic rel_last;
        logic clr_last;
    } sts_t;

endpackage

// ===== rtl/contiguous_page_run_allocator.sv =====
// Top level of the contiguous page run allocator.
// Next-fit page run allocator over an arena of ARENA_PAGES pages. After reset the block
// first clears its used-page bitmap and run length store, one page per cycle, so s_ready
// stays low until the clearing pass is done. An item with s_op = 0 asks for s_request_pages
// contiguous pages; the search reads the bitmap one page per cycle through a single read
// port, first from the search hint to the end of the arena and then from page 0 up to the
// hint, so each page is read at most once, and a placed run is then marked one page per
// cycle. An item with s_op = 1 releases the run that starts at s_start_page. A result
// also waits while the previous one is still held on m_ready. One item is worked on at a
// time; the result sits in an output register, so a new item can be taken while the
// previous result still waits on m_ready, from the cycle in which it is first offered.
module contiguous_page_run_allocator #(
    parameter int ARENA_PAGES = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [cpra_pkg::W_OP-1:0]         s_op,
    input  logic [cpra_pkg::W_REQ-1:0]        s_request_pages,
    input  logic [cpra_pkg::W_PAGE_IN-1:0]    s_start_page,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_granted,
    output logic [cpra_pkg::W_RUN_START-1:0]  m_run_start,
    output logic [cpra_pkg::W_COUNT-1:0]      m_live_count,
    output logic [cpra_pkg::W_COUNT-1:0]      m_peak_count
);

    cpra_pkg::cmd_t cmd;
    cpra_pkg::sts_t sts;

    cpra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    cpra_dp #(
        .ARENA_PAGES (ARENA_PAGES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_op            (s_op),
        .s_request_pages (s_request_pages),
        .s_start_page    (s_start_page),
        .m_granted       (m_granted),
        .m_run_start     (m_run_start),
        .m_live_count    (m_live_count),
        .m_peak_count    (m_peak_count)
    );

endmodule

// ===== rtl/cpra_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
module cpra_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cpra_ctrl.sv =====
// Controller state machine for the contiguous page run allocator.
module cpra_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output cpra_pkg::cmd_t cmd,
    input  cpra_pkg::sts_t sts
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN1,
        ST_SCAN2,
        ST_MARK,
        ST_FREE_LEN,
        ST_RELEASE,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!sts.op_free) begin
                    if (sts.want_bad) begin
                        cmd.set_fail = 1'b1;
                        state_next   = ST_RESP;
                    end else begin
                        cmd.scan_p1 = 1'b1;
                        state_next  = ST_SCAN1;
                    end
                end else begin
                    if (sts.page_bad) begin
                        cmd.set_fail = 1'b1;
                        state_next   = ST_RESP;
                    end else begin
                        state_next = ST_FREE_LEN;
                    end
                end
            end
            ST_SCAN1: begin
                cmd.scan = 1'b1;
                if (sts.hit) begin
                    state_next = ST_MARK;
                end else if (sts.pass_done) begin
                    cmd.scan_p2 = 1'b1;
                    state_next  = ST_SCAN2;
                end
            end
            ST_SCAN2: begin
                cmd.scan = 1'b1;
                if (sts.hit) begin
                    state_next = ST_MARK;
                end else if (sts.pass_done) begin
                    cmd.set_fail = 1'b1;
                    state_next   = ST_RESP;
                end
            end
            ST_MARK: begin
                cmd.mark = 1'b1;
                if (sts.mark_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_FREE_LEN: begin
                if (sts.len_zero) begin
                    cmd.set_fail = 1'b1;
                    state_next   = ST_RESP;
                end else begin
                    cmd.rel_start = 1'b1;
                    state_next    = ST_RELEASE;
                end
            end
            ST_RELEASE: begin
                cmd.release_pg = 1'b1;
                if (sts.rel_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                // The result waits here only while the previous one is still held.
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/cpra_dp.sv =====
// Datapath of the page run allocator: bitmap and run length stores, scan and counters.
module cpra_dp #(
    parameter int ARENA_PAGES = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cpra_pkg::cmd_t                    cmd,
    output cpra_pkg::sts_t                    sts,
    input  logic [cpra_pkg::W_OP-1:0]         s_op,
    input  logic [cpra_pkg::W_REQ-1:0]        s_request_pages,
    input  logic [cpra_pkg::W_PAGE_IN-1:0]    s_start_page,
    output logic                              m_granted,
    output logic [cpra_pkg::W_RUN_START-1:0]  m_run_start,
    output logic [cpra_pkg::W_COUNT-1:0]      m_live_count,
    output logic [cpra_pkg::W_COUNT-1:0]      m_peak_count
);

    localparam int PW = $clog2(ARENA_PAGES);
    localparam int LW = $clog2(ARENA_PAGES + 1);
    localparam int IW = PW + 1;
    localparam int XW = (PW + 2 > cpra_pkg::W_REQ) ? PW + 2 : cpra_pkg::W_REQ;
    localparam logic [XW-1:0] ARENA_X = XW'(ARENA_PAGES);
    localparam logic [IW-1:0] ARENA_I = IW'(ARENA_PAGES);
    localparam logic [PW-1:0] LAST_P  = PW'(ARENA_PAGES - 1);

    // Captured item.
    cpra_pkg::op_t   op_reg;
    logic [XW-1:0]   want_x_reg;
    logic [XW-1:0]   page_x_reg;
    logic [LW-1:0]   want;
    logic [PW-1:0]   page;

    // Scan pipeline: issue stage and check stage.
    logic [IW-1:0]   iss_reg, iss_next;
    logic            pass2_reg, pass2_next;
    logic            chk_v_reg, chk_v_next;
    logic [PW-1:0]   chk_addr_reg;
    logic [LW-1:0]   cnt_reg, cnt_next;
    logic [LW-1:0]   cnt_inc;
    logic [IW-1:0]   limit;
    logic            issue;
    logic            hit;
    logic [IW-1:0]   at_sum;
    logic [PW-1:0]   at_reg;

    // Mark, release and clearing sweeps.
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [LW-1:0]   rem_reg, rem_next;
    logic [LW-1:0]   len_reg;
    logic            mark_last;
    logic            rel_last;
    logic            clr_last;

    // Allocator state.
    logic [PW-1:0]   hint_reg, hint_next;
    logic [LW-1:0]   live_reg, live_next;
    logic [LW-1:0]   peak_reg, peak_next;
    logic [IW-1:0]   end_sum;
    logic [LW-1:0]   live_add;
    logic [LW-1:0]   live_sub;

    // Result.
    logic            res_ok_reg;
    logic [PW-1:0]   res_start_reg;
    logic            m_granted_reg;
    logic [cpra_pkg::W_RUN_START-1:0] m_run_start_reg;
    logic [cpra_pkg::W_COUNT-1:0]     m_live_count_reg;
    logic [cpra_pkg::W_COUNT-1:0]     m_peak_count_reg;
    logic [PW+cpra_pkg::W_RUN_START-1:0] start_wide;
    logic [LW+cpra_pkg::W_COUNT-1:0]     live_wide;
    logic [LW+cpra_pkg::W_COUNT-1:0]     peak_wide;

    // Store ports.
    logic            used_we;
    logic [0:0]      used_wdata;
    logic [0:0]      used_rd;
    logic            len_we;
    logic [PW-1:0]   len_waddr;
    logic [LW-1:0]   len_wdata;
    logic [LW-1:0]   len_rd;

    assign want = want_x_reg[LW-1:0];
    assign page = page_x_reg[PW-1:0];

    assign limit    = pass2_reg ? {1'b0, hint_reg} : ARENA_I;
    assign issue    = (iss_reg < limit);
    assign cnt_inc  = cnt_reg + LW'(1);
    assign hit      = chk_v_reg && !used_rd[0] && (cnt_inc == want);
    // A run of the requested length ends at the page being checked.
    assign at_sum   = {1'b0, chk_addr_reg} + IW'(1) - IW'(want);

    assign mark_last = (rem_reg == LW'(1));
    assign rel_last  = (rem_reg == LW'(1)) || (wr_ptr_reg == LAST_P);
    assign clr_last  = (wr_ptr_reg == LAST_P);

    assign end_sum  = {1'b0, at_reg} + IW'(want);
    assign live_add = live_reg + want;
    assign live_sub = (live_reg >= len_reg) ? (live_reg - len_reg) : '0;

    always_comb begin
        sts           = '0;
        sts.op_free   = (op_reg == cpra_pkg::OP_FREE);
        sts.want_bad  = (want_x_reg == '0) || (want_x_reg > ARENA_X);
        sts.page_bad  = (page_x_reg >= ARENA_X);
        sts.hit       = hit;
        sts.pass_done = !chk_v_reg && !issue;
        sts.mark_last = mark_last;
        sts.len_zero  = (len_rd == '0);
        sts.rel_last  = rel_last;
        sts.clr_last  = clr_last;
    end

    always_comb begin
        iss_next    = iss_reg;
        pass2_next  = pass2_reg;
        chk_v_next  = 1'b0;
        cnt_next    = cnt_reg;
        wr_ptr_next = wr_ptr_reg;
        rem_next    = rem_reg;
        hint_next   = hint_reg;
        live_next   = live_reg;
        peak_next   = peak_reg;
        if (cmd.scan_p1) begin
            iss_next   = {1'b0, hint_reg};
            pass2_next = 1'b0;
            cnt_next   = '0;
        end else if (cmd.scan_p2) begin
            iss_next   = '0;
            pass2_next = 1'b1;
            cnt_next   = '0;
        end else if (cmd.scan) begin
            if (issue) begin
                chk_v_next = 1'b1;
                iss_next   = iss_reg + IW'(1);
            end
            if (chk_v_reg) begin
                cnt_next = used_rd[0] ? '0 : cnt_inc;
            end
            if (hit) begin
                wr_ptr_next = at_sum[PW-1:0];
                rem_next    = want;
            end
        end
        if (cmd.clear) begin
            wr_ptr_next = clr_last ? '0 : wr_ptr_reg + PW'(1);
        end
        if (cmd.rel_start) begin
            wr_ptr_next = page;
            rem_next    = len_rd;
        end
        if (cmd.mark || cmd.release_pg) begin
            wr_ptr_next = wr_ptr_reg + PW'(1);
            rem_next    = rem_reg - LW'(1);
        end
        if (cmd.mark && mark_last) begin
            hint_next = (end_sum >= ARENA_I) ? '0 : end_sum[PW-1:0];
            live_next = live_add;
            if (live_add > peak_reg) begin
                peak_next = live_add;
            end
        end
        if (cmd.release_pg && rel_last) begin
            live_next = live_sub;
            if (page < hint_reg) begin
                hint_next = page;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_reg    <= '0;
            pass2_reg  <= 1'b0;
            chk_v_reg  <= 1'b0;
            cnt_reg    <= '0;
            wr_ptr_reg <= '0;
            rem_reg    <= '0;
            hint_reg   <= '0;
            live_reg   <= '0;
            peak_reg   <= '0;
        end else begin
            iss_reg    <= iss_next;
            pass2_reg  <= pass2_next;
            chk_v_reg  <= chk_v_next;
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rem_reg    <= rem_next;
            hint_reg   <= hint_next;
            live_reg   <= live_next;
            peak_reg   <= peak_next;
        end
    end

    assign start_wide = {{cpra_pkg::W_RUN_START{1'b0}}, res_start_reg};
    assign live_wide  = {{cpra_pkg::W_COUNT{1'b0}}, live_reg};
    assign peak_wide  = {{cpra_pkg::W_COUNT{1'b0}}, peak_reg};

    always_ff @(posedge aclk) begin
        chk_addr_reg <= iss_reg[PW-1:0];
        if (cmd.load) begin
            op_reg     <= cpra_pkg::op_t'(s_op);
            want_x_reg <= XW'(s_request_pages);
            page_x_reg <= XW'(s_start_page);
        end
        if (cmd.scan && hit) begin
            at_reg <= at_sum[PW-1:0];
        end
        if (cmd.rel_start) begin
            len_reg <= len_rd;
        end
        if (cmd.set_fail) begin
            res_ok_reg    <= 1'b0;
            res_start_reg <= '0;
        end
        if (cmd.mark && mark_last) begin
            res_ok_reg    <= 1'b1;
            res_start_reg <= at_reg;
        end
        if (cmd.release_pg && rel_last) begin
            res_ok_reg    <= 1'b1;
            res_start_reg <= page;
        end
        if (cmd.out_load) begin
            m_granted_reg    <= res_ok_reg;
            m_run_start_reg  <= start_wide[cpra_pkg::W_RUN_START-1:0];
            m_live_count_reg <= live_wide[cpra_pkg::W_COUNT-1:0];
            m_peak_count_reg <= peak_wide[cpra_pkg::W_COUNT-1:0];
        end
    end

    assign m_granted    = m_granted_reg;
    assign m_run_start  = m_run_start_reg;
    assign m_live_count = m_live_count_reg;
    assign m_peak_count = m_peak_count_reg;

    // The used bitmap is only ever written at the sweep pointer.
    assign used_we    = cmd.clear || cmd.mark || cmd.release_pg;
    assign used_wdata = cmd.mark;

    always_comb begin
        len_we    = cmd.clear || (cmd.mark && mark_last) || cmd.rel_start;
        len_waddr = page;
        len_wdata = '0;
        if (cmd.clear) begin
            len_waddr = wr_ptr_reg;
        end else if (cmd.mark) begin
            len_waddr = at_reg;
            len_wdata = want;
        end
    end

    cpra_ram #(
        .WIDTH (1),
        .DEPTH (ARENA_PAGES)
    ) u_used_ram (
        .aclk  (aclk),
        .we    (used_we),
        .waddr (wr_ptr_reg),
        .wdata (used_wdata),
        .raddr (iss_reg[PW-1:0]),
        .rdata (used_rd)
    );

    cpra_ram #(
        .WIDTH (LW),
        .DEPTH (ARENA_PAGES)
    ) u_len_ram (
        .aclk  (aclk),
        .we    (len_we),
        .waddr (len_waddr),
        .wdata (len_wdata),
        .raddr (page),
        .rdata (len_rd)
    );

    a_live_le_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= peak_reg)
        else $error("live page count exceeds the peak count");

    a_live_in_arena: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, live_reg} <= (LW + 1)'(ARENA_PAGES))
        else $error("live page count exceeds the arena");

    a_hint_in_arena: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, hint_reg} < ARENA_I)
        else $error("search hint lies outside the arena");

    a_hit_in_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan && hit) |-> (({1'b0, chk_addr_reg} + IW'(1)) <= limit))
        else $error("placed run extends past the end of the search pass");

    a_commit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mark && mark_last) |=> (live_reg != '0) && (hint_reg == $past(hint_next)))
        else $error("allocation committed with no live pages");

endmodule

// ===== tb/contiguous_page_run_allocator_checker.sv =====
// Predicts and checks the results of the contiguous page run allocator.
`timescale 1ns / 1ps

module contiguous_page_run_allocator_checker #(
    parameter int ARENA_PAGES = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [cpra_pkg::W_OP-1:0]        s_op,
    input  logic [cpra_pkg::W_REQ-1:0]       s_request_pages,
    input  logic [cpra_pkg::W_PAGE_IN-1:0]   s_start_page,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic                             m_granted,
    input  logic [cpra_pkg::W_RUN_START-1:0] m_run_start,
    input  logic [cpra_pkg::W_COUNT-1:0]     m_live_count,
    input  logic [cpra_pkg::W_COUNT-1:0]     m_peak_count,
    output int                               mismatch_count,
    output int                               pending_results
);

    localparam int W_REQ       = cpra_pkg::W_REQ;
    localparam int W_PAGE_IN   = cpra_pkg::W_PAGE_IN;
    localparam int W_RUN_START = cpra_pkg::W_RUN_START;
    localparam int W_COUNT     = cpra_pkg::W_COUNT;

    typedef struct packed {
        logic                   granted;
        logic [W_RUN_START-1:0] run_start;
        logic [W_COUNT-1:0]     live_count;
        logic [W_COUNT-1:0]     peak_count;
    } outcome_t;

    bit               used_map [ARENA_PAGES];
    logic [W_COUNT-1:0] run_len [ARENA_PAGES];
    int unsigned      hint;
    int unsigned      live_pages;
    int unsigned      peak_pages;
    outcome_t         outcomes_due[$];
    outcome_t         due;
    int               errors = 0;

    function automatic outcome_t outcome_now(logic ok, int unsigned first);
        outcome_t o;
        o.granted    = ok;
        o.run_start  = W_RUN_START'(first);
        o.live_count = W_COUNT'(live_pages);
        o.peak_count = W_COUNT'(peak_pages);
        return o;
    endfunction

    // Looks for the first free stretch of len pages inside [lo, hi).
    function automatic bit first_free_run(int unsigned lo, int unsigned hi, int unsigned len,
                                          output int unsigned at);
        int unsigned pos;
        int unsigned got;
        pos = lo;
        at  = 0;
        while (pos + len <= hi) begin
            got = 0;
            while (got < len && !used_map[pos + got])
                got++;
            if (got == len) begin
                at = pos;
                return 1'b1;
            end
            pos += got + 1;
        end
        return 1'b0;
    endfunction

    function automatic outcome_t predict_request(cpra_pkg::op_t op, logic [W_REQ-1:0] want,
                                                 logic [W_PAGE_IN-1:0] page);
        int unsigned at;
        int unsigned n;
        bit hit;
        if (op == cpra_pkg::OP_ALLOC) begin
            if (want == 0 || want > ARENA_PAGES)
                return outcome_now(1'b0, 0);
            hit = first_free_run(hint, ARENA_PAGES, want, at);
            if (!hit)
                hit = first_free_run(0, hint, want, at);
            if (!hit)
                return outcome_now(1'b0, 0);
            for (int k = 0; k < want; k++)
                used_map[at + k] = 1'b1;
            run_len[at] = W_COUNT'(want);
            hint = at + want;
            if (hint >= ARENA_PAGES)
                hint = 0;
            live_pages += want;
            if (live_pages > peak_pages)
                peak_pages = live_pages;
            return outcome_now(1'b1, at);
        end
        if (page >= ARENA_PAGES || run_len[page] == 0)
            return outcome_now(1'b0, 0);
        n = run_len[page];
        for (int k = 0; k < n && page + k < ARENA_PAGES; k++)
            used_map[page + k] = 1'b0;
        run_len[page] = '0;
        live_pages = (live_pages >= n) ? live_pages - n : 0;
        if (page < hint)
            hint = page;
        return outcome_now(1'b1, page);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ARENA_PAGES; i++) begin
                used_map[i] = 1'b0;
                run_len[i]  = '0;
            end
            hint       = 0;
            live_pages = 0;
            peak_pages = 0;
            outcomes_due.delete();
        end else begin
            if (s_valid && s_ready)
                outcomes_due.push_back(predict_request(cpra_pkg::op_t'(s_op),
                                                       s_request_pages, s_start_page));
            if (m_valid && m_ready) begin
                if (outcomes_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with none outstanding: %s%0d %s%0d %s%0d %s%0d",
                                 $time, "granted=", m_granted, "start=", m_run_start,
                                 "live=", m_live_count, "peak=", m_peak_count);
                end else begin
                    due = outcomes_due.pop_front();
                    if (m_granted !== due.granted || m_run_start !== due.run_start ||
                        m_live_count !== due.live_count ||
                        m_peak_count !== due.peak_count) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: expected granted=%0d start=%0d live=%0d peak=%0d",
                                     $time, due.granted, due.run_start, due.live_count,
                                     due.peak_count);
                            $display("%0t:      got granted=%0d start=%0d live=%0d peak=%0d",
                                     $time, m_granted, m_run_start, m_live_count,
                                     m_peak_count);
                        end
                    end
                end
            end
        end
        pending_results <= outcomes_due.size();
        mismatch_count  <= errors;
    end

endmodule

// ===== tb/contiguous_page_run_allocator_tb.sv =====
// Stimulus and verdict for the contiguous page run allocator.
`timescale 1ns / 1ps

module contiguous_page_run_allocator_tb;

    localparam int W_OP         = cpra_pkg::W_OP;
    localparam int W_REQ        = cpra_pkg::W_REQ;
    localparam int W_PAGE_IN    = cpra_pkg::W_PAGE_IN;
    localparam int W_RUN_START  = cpra_pkg::W_RUN_START;
    localparam int W_COUNT      = cpra_pkg::W_COUNT;
    localparam int ARENA_PAGES  = 1024;
    localparam int LIMIT_CYCLES = 5_000_000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASE_ITEMS  = 65;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [W_OP-1:0]        s_op = cpra_pkg::OP_ALLOC;
    logic [W_REQ-1:0]       s_request_pages = '0;
    logic [W_PAGE_IN-1:0]   s_start_page = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_granted;
    logic [W_RUN_START-1:0] m_run_start;
    logic [W_COUNT-1:0]     m_live_count;
    logic [W_COUNT-1:0]     m_peak_count;

    int            mismatch_count;
    int            pending_results;
    int            gap_pct = 0;
    int            stall_pct = 0;
    int            hold_ask = 0;
    int            hold_done = 0;
    int unsigned   cycles = 0;
    cpra_pkg::op_t ops_sent[$];
    int unsigned   live_starts[$];
    int            gap_pcts[4]   = '{0, 81, 0, 25};
    int            stall_pcts[4] = '{0, 0, 81, 25};

    always #5 aclk = ~aclk;

    contiguous_page_run_allocator #(.ARENA_PAGES(ARENA_PAGES)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_request_pages(s_request_pages), .s_start_page(s_start_page),
        .m_valid(m_valid), .m_ready(m_ready), .m_granted(m_granted),
        .m_run_start(m_run_start), .m_live_count(m_live_count), .m_peak_count(m_peak_count)
    );

    contiguous_page_run_allocator_checker #(.ARENA_PAGES(ARENA_PAGES)) grant_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_request_pages(s_request_pages), .s_start_page(s_start_page),
        .m_valid(m_valid), .m_ready(m_ready), .m_granted(m_granted),
        .m_run_start(m_run_start), .m_live_count(m_live_count), .m_peak_count(m_peak_count),
        .mismatch_count(mismatch_count), .pending_results(pending_results)
    );

    // Receiver: random stalls, plus one long hold-off when the stimulus asks for it.
    always begin
        @(posedge aclk);
        if (hold_ask != hold_done) begin
            hold_done = hold_ask;
            m_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge aclk);
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Granted allocations give the run starts that later frees aim at.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready && ops_sent.size() > 0) begin
            if (ops_sent.pop_front() == cpra_pkg::OP_ALLOC && m_granted)
                live_starts.push_back(m_run_start);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_item(input cpra_pkg::op_t op, input logic [W_REQ-1:0] want,
                             input logic [W_PAGE_IN-1:0] page);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_op            <= op;
        s_request_pages <= want;
        s_start_page    <= page;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        ops_sent.push_back(op);
    endtask

    task automatic await_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0)
            @(posedge aclk);
    endtask

    task automatic random_item();
        int unsigned pick;
        int unsigned page;
        int unsigned free_pct;
        logic [W_REQ-1:0] want;
        free_pct = (live_starts.size() > 24) ? 60 : 42;
        if ($urandom_range(99) < 8) begin
            case ($urandom_range(3))
                0, 1: send_item(cpra_pkg::OP_FREE, W_REQ'($urandom_range(4095)),
                                W_PAGE_IN'($urandom_range(1023)));
                2:    send_item(cpra_pkg::OP_ALLOC, '0, W_PAGE_IN'($urandom_range(1023)));
                default: send_item(cpra_pkg::OP_ALLOC,
                                   W_REQ'($urandom_range(4095, ARENA_PAGES + 1)),
                                   W_PAGE_IN'($urandom_range(1023)));
            endcase
        end else if (live_starts.size() > 0 && $urandom_range(99) < free_pct) begin
            pick = $urandom_range(live_starts.size() - 1);
            page = live_starts[pick];
            live_starts.delete(pick);
            send_item(cpra_pkg::OP_FREE, W_REQ'($urandom_range(4095)), W_PAGE_IN'(page));
        end else begin
            pick = $urandom_range(99);
            if (pick < 75)
                want = W_REQ'($urandom_range(8, 1));
            else if (pick < 95)
                want = W_REQ'($urandom_range(64, 9));
            else
                want = W_REQ'($urandom_range(300, 65));
            send_item(cpra_pkg::OP_ALLOC, want, W_PAGE_IN'($urandom_range(1023)));
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Rejections on an empty arena, and frees where no run starts.
        send_item(cpra_pkg::OP_ALLOC, 0, 0);
        send_item(cpra_pkg::OP_ALLOC, 4095, 1023);
        send_item(cpra_pkg::OP_ALLOC, W_REQ'(ARENA_PAGES + 1), 0);
        send_item(cpra_pkg::OP_FREE, 4095, 0);
        send_item(cpra_pkg::OP_FREE, 0, 1023);
        // The whole arena in one run: the hint wraps, then nothing more fits.
        send_item(cpra_pkg::OP_ALLOC, W_REQ'(ARENA_PAGES), 0);
        send_item(cpra_pkg::OP_ALLOC, 1, 0);
        send_item(cpra_pkg::OP_FREE, 0, 5);
        send_item(cpra_pkg::OP_FREE, 0, 0);
        send_item(cpra_pkg::OP_FREE, 0, 0);
        // Leaves pages 0 to 2 free with the hint at page 1, so a run of three
        // would have to straddle the hint and is refused.
        send_item(cpra_pkg::OP_ALLOC, 1, 0);
        send_item(cpra_pkg::OP_ALLOC, 2, 0);
        send_item(cpra_pkg::OP_ALLOC, W_REQ'(ARENA_PAGES - 6), 0);
        send_item(cpra_pkg::OP_FREE, 0, 0);
        send_item(cpra_pkg::OP_ALLOC, 2, 0);
        send_item(cpra_pkg::OP_FREE, 0, 1);
        send_item(cpra_pkg::OP_ALLOC, 3, 0);
        send_item(cpra_pkg::OP_ALLOC, 2, 0);
        send_item(cpra_pkg::OP_ALLOC, 1, 0);
        send_item(cpra_pkg::OP_ALLOC, 1, 0);
        send_item(cpra_pkg::OP_ALLOC, 2048, 0);
        await_drain();

        for (int ph = 0; ph < 4; ph++) begin
            gap_pct = gap_pcts[ph];
            stall_pct <= stall_pcts[ph];
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_item();
            await_drain();
            if (ph == 0) begin
                // Hold the result side off while items keep coming, so the
                // block fills up and has to stall its input.
                hold_ask <= hold_ask + 1;
                for (int i = 0; i < 8; i++)
                    send_item(cpra_pkg::OP_ALLOC, W_REQ'($urandom_range(4, 1)),
                              W_PAGE_IN'($urandom_range(1023)));
                await_drain();
            end
        end

        stall_pct <= 0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
